// ===== hdl/fmprt_pkg.sv =====
// ---------------------------------------------------------------------------
// First-match rule table package
// Shared types and codes for the two-chain first-match rule table.
// ---------------------------------------------------------------------------
package fmprt_pkg;

   typedef enum logic [1:0] {
      OP_CLASSIFY = 2'd0,
      OP_INSERT   = 2'd1,
      OP_APPEND   = 2'd2,
      OP_DELETE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      VERDICT_ACCEPT = 2'd0,
      VERDICT_DROP   = 2'd1,
      VERDICT_NONE   = 2'd2
   } verdict_type;

   localparam logic STATUS_ACK  = 1'b0;
   localparam logic STATUS_NACK = 1'b1;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   localparam int CHK_SRC   = 0;
   localparam int CHK_DST   = 1;
   localparam int CHK_PROTO = 2;
   localparam int CHK_SPORT = 3;
   localparam int CHK_DPORT = 4;
   localparam int INV_OFS   = 5;

   typedef struct packed {
      logic [31:0] src;
      logic [31:0] src_mask;
      logic [31:0] dst;
      logic [31:0] dst_mask;
      logic [7:0]  proto;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [9:0]  flags;
      logic        accept;
   } rule_type;

endpackage

// ===== hdl/fmprt_rule_mem.sv =====
// ---------------------------------------------------------------------------
// Rule memory
// One write port and one read port with registered read data; both chains
// share the array, the chain number being the top address bit.
// ---------------------------------------------------------------------------
module fmprt_rule_mem
   import fmprt_pkg::*;
#(
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  rule_type          wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output rule_type          rd_data
);

   rule_type mem_ff [2**ADDR_W];
   rule_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fmprt_match.sv =====
// ---------------------------------------------------------------------------
// Rule compare unit
// Checks one stored rule against the packet header held by the sequencer.
// ---------------------------------------------------------------------------
module fmprt_match
   import fmprt_pkg::*;
(
   input  rule_type    rule,
   input  logic [31:0] pkt_src,
   input  logic [31:0] pkt_dst,
   input  logic [7:0]  pkt_proto,
   input  logic [15:0] pkt_sport,
   input  logic [15:0] pkt_dport,
   output logic        hit
);

   logic [4:0] differs;
   logic [4:0] passes;
   logic       ports_valid;

   always_comb begin
      differs[CHK_SRC]   = (pkt_src & rule.src_mask) != rule.src;
      differs[CHK_DST]   = (pkt_dst & rule.dst_mask) != rule.dst;
      differs[CHK_PROTO] = pkt_proto != rule.proto;
      differs[CHK_SPORT] = pkt_sport != rule.sport;
      differs[CHK_DPORT] = pkt_dport != rule.dport;
      for (int k = 0; k < 5; k++) begin
         passes[k] = !rule.flags[k] || (differs[k] == rule.flags[k + INV_OFS]);
      end
      ports_valid = (pkt_proto == PROTO_TCP) || (pkt_proto == PROTO_UDP);
      hit = (&passes) && ports_valid;
   end

endmodule

// ===== hdl/first_match_packet_rule_table.sv =====
// ---------------------------------------------------------------------------
// First-match packet rule table
// Two ordered rule chains with insert, append, delete and first-match
// classify, run by a sequencer over one memory port and one compare unit.
// ---------------------------------------------------------------------------
// Classify reads rules in order via ST_READ and ST_EXEC until one hits or
// the chain ends; insert and delete shift rules one at a time the same way,
// and insert then writes the new rule in ST_PUT. The result strobe is
// registered. Simple cases answer straight from ST_IDLE. One transaction
// runs at a time, as start is taken only in ST_IDLE; the receiver cannot
// stall, so a result never waits. Reset empties both chains, not rule memory.
// ---------------------------------------------------------------------------
module first_match_packet_rule_table
   import fmprt_pkg::*;
#(
   parameter int RULES_PER_CHAIN = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic        req_chain,
   input  logic [7:0]  req_position,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_src_netmask,
   input  logic [31:0] req_dst_ip,
   input  logic [31:0] req_dst_netmask,
   input  logic [7:0]  req_protocol,
   input  logic [15:0] req_sport,
   input  logic [15:0] req_dport,
   input  logic [9:0]  req_rule_flags,
   input  logic        req_rule_accept,
   output logic        rsp_valid,
   output logic        rsp_status,
   output logic [1:0]  rsp_verdict,
   output logic [4:0]  rsp_hit_position
);

   localparam int IDX_W  = (RULES_PER_CHAIN > 1) ? $clog2(RULES_PER_CHAIN) : 1;
   localparam int ADDR_W = IDX_W + 1;
   localparam int LEN_W  = $clog2(RULES_PER_CHAIN + 1);
   localparam int CW     = (LEN_W > 8) ? LEN_W : 8;
   localparam logic [CW-1:0] MAX_LEN = CW'(RULES_PER_CHAIN);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_EXEC = 4'b0100,
      ST_PUT  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   op_type      op_ff, op_in;
   logic        chain_ff, chain_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] at_ff, at_in;
   rule_type    rule_ff, rule_in;
   logic [LEN_W-1:0] len_ff [2];
   logic [LEN_W-1:0] len_in [2];

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_status_ff, rsp_status_in;
   verdict_type rsp_verdict_ff, rsp_verdict_in;
   logic [4:0]  rsp_hit_ff, rsp_hit_in;

   logic        mem_wr_en;
   rule_type    mem_wr_data;
   logic        mem_rd_en;
   logic [CW-1:0] rd_idx;
   rule_type    mem_rd_data;
   logic        match_hit;

   logic [CW-1:0] len_req;
   logic [CW-1:0] len_cur;
   logic [CW-1:0] pos_req;
   op_type      op_req;

   fmprt_rule_mem #(
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr ({chain_ff, i_ff[IDX_W-1:0]}),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr ({chain_ff, rd_idx[IDX_W-1:0]}),
      .rd_data (mem_rd_data)
   );

   fmprt_match u_match (
      .rule      (mem_rd_data),
      .pkt_src   (rule_ff.src),
      .pkt_dst   (rule_ff.dst),
      .pkt_proto (rule_ff.proto),
      .pkt_sport (rule_ff.sport),
      .pkt_dport (rule_ff.dport),
      .hit       (match_hit)
   );

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      chain_in       = chain_ff;
      i_in           = i_ff;
      at_in          = at_ff;
      rule_in        = rule_ff;
      len_in         = len_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_hit_in     = rsp_hit_ff;
      mem_wr_en      = 1'b0;
      mem_wr_data    = mem_rd_data;
      mem_rd_en      = 1'b0;

      op_req  = op_type'(req_operation);
      len_req = CW'(len_ff[req_chain]);
      pos_req = CW'(req_position);
      len_cur = CW'(len_ff[chain_ff]);

      case (op_ff)
         OP_INSERT, OP_APPEND: rd_idx = i_ff - CW'(1);
         OP_DELETE:            rd_idx = i_ff + CW'(1);
         default:              rd_idx = i_ff;
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = op_req;
               chain_in = req_chain;
               rule_in  = '{src: req_src_ip, src_mask: req_src_netmask,
                            dst: req_dst_ip, dst_mask: req_dst_netmask,
                            proto: req_protocol, sport: req_sport,
                            dport: req_dport, flags: req_rule_flags,
                            accept: req_rule_accept};
               rsp_status_in  = STATUS_ACK;
               rsp_verdict_in = VERDICT_ACCEPT;
               rsp_hit_in     = '0;
               case (op_req)
                  OP_CLASSIFY: begin
                     i_in = '0;
                     if (len_req == '0) begin
                        rsp_valid_in   = 1'b1;
                        rsp_verdict_in = VERDICT_NONE;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  OP_INSERT, OP_APPEND: begin
                     if (len_req >= MAX_LEN) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_NACK;
                     end else begin
                        if (op_req == OP_APPEND || pos_req > len_req) begin
                           at_in = len_req;
                        end else begin
                           at_in = pos_req;
                        end
                        i_in = len_req;
                        state_in = (at_in == len_req) ? ST_PUT : ST_READ;
                     end
                  end
                  default: begin
                     if (pos_req >= len_req) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_NACK;
                     end else if (pos_req + CW'(1) == len_req) begin
                        len_in[req_chain] = len_ff[req_chain] - LEN_W'(1);
                        rsp_valid_in      = 1'b1;
                     end else begin
                        i_in     = pos_req;
                        state_in = ST_READ;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            mem_rd_en = 1'b1;
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            case (op_ff)
               OP_CLASSIFY: begin
                  if (match_hit) begin
                     rsp_valid_in   = 1'b1;
                     rsp_verdict_in = mem_rd_data.accept ? VERDICT_ACCEPT : VERDICT_DROP;
                     rsp_hit_in     = i_ff[4:0];
                     state_in       = ST_IDLE;
                  end else if (i_ff + CW'(1) == len_cur) begin
                     rsp_valid_in   = 1'b1;
                     rsp_verdict_in = VERDICT_NONE;
                     state_in       = ST_IDLE;
                  end else begin
                     i_in     = i_ff + CW'(1);
                     state_in = ST_READ;
                  end
               end
               OP_INSERT, OP_APPEND: begin
                  mem_wr_en = 1'b1;
                  i_in      = i_ff - CW'(1);
                  state_in  = (i_in == at_ff) ? ST_PUT : ST_READ;
               end
               default: begin
                  mem_wr_en = 1'b1;
                  i_in      = i_ff + CW'(1);
                  if (i_in + CW'(1) == len_cur) begin
                     len_in[chain_ff] = len_ff[chain_ff] - LEN_W'(1);
                     rsp_valid_in     = 1'b1;
                     state_in         = ST_IDLE;
                  end else begin
                     state_in = ST_READ;
                  end
               end
            endcase
         end
         ST_PUT: begin
            mem_wr_en        = 1'b1;
            mem_wr_data      = rule_ff;
            len_in[chain_ff] = len_ff[chain_ff] + LEN_W'(1);
            rsp_valid_in     = 1'b1;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff[0]    <= '0;
         len_ff[1]    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      chain_ff       <= chain_in;
      i_ff           <= i_in;
      at_ff          <= at_in;
      rule_ff        <= rule_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_hit_ff     <= rsp_hit_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_verdict      = rsp_verdict_ff;
   assign rsp_hit_position = rsp_hit_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (CW'(len_ff[0]) <= MAX_LEN) && (CW'(len_ff[1]) <= MAX_LEN))
      else $error("chain length exceeds capacity");

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(start || state_ff != ST_IDLE))
      else $error("result without a transaction in progress");

   a_nack_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_NACK) |->
         (rsp_verdict_ff == VERDICT_ACCEPT && rsp_hit_ff == '0))
      else $error("nack carries classify fields");

   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy)
      else $error("result issued while sequencer still running");

endmodule

// ===== test/first_match_packet_rule_table_test.sv =====
// ---------------------------------------------------------------------------
// First-match packet rule table testbench
// Drives insert, append, delete and classify transactions into both chains,
// predicts every answer from a private copy of the chains and compares each
// result strobe with the oldest predicted answer.
// ---------------------------------------------------------------------------
module first_match_packet_rule_table_test
   import fmprt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RULES_PER_CHAIN = 32;

   typedef struct {
      op_type      operation;
      logic        chain;
      logic [7:0]  position;
      logic [31:0] src_ip;
      logic [31:0] src_netmask;
      logic [31:0] dst_ip;
      logic [31:0] dst_netmask;
      logic [7:0]  protocol;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [9:0]  rule_flags;
      logic        rule_accept;
   } request_type;

   typedef struct {
      logic        status;
      logic [1:0]  verdict;
      logic [4:0]  hit;
   } answer_type;

   class verdict_tracker_type;
      rule_type   rules[2][RULES_PER_CHAIN];
      int         counts[2];
      answer_type pending_answers[$];
      int         failures;

      function new();
         counts[0] = 0;
         counts[1] = 0;
         failures = 0;
      endfunction

      static function bit check_ok(logic [9:0] flags, int idx, bit differs);
         return !flags[idx] || (differs == flags[idx + INV_OFS]);
      endfunction

      function void record_request(request_type rq);
         answer_type ans;
         rule_type   r;
         int         len;
         int         at;
         int         i;
         bit         ports_valid;
         len = counts[rq.chain];
         ans.status = STATUS_ACK;
         ans.verdict = VERDICT_ACCEPT;
         ans.hit = '0;
         case (rq.operation)
            OP_CLASSIFY: begin
               ans.verdict = VERDICT_NONE;
               ports_valid = (rq.protocol == PROTO_TCP) || (rq.protocol == PROTO_UDP);
               for (i = 0; i < len; i++) begin
                  r = rules[rq.chain][i];
                  if (!check_ok(r.flags, CHK_SRC, (rq.src_ip & r.src_mask) != r.src))
                     continue;
                  if (!check_ok(r.flags, CHK_DST, (rq.dst_ip & r.dst_mask) != r.dst))
                     continue;
                  if (!check_ok(r.flags, CHK_PROTO, rq.protocol != r.proto))
                     continue;
                  if (!ports_valid)
                     continue;
                  if (!check_ok(r.flags, CHK_SPORT, rq.sport != r.sport))
                     continue;
                  if (!check_ok(r.flags, CHK_DPORT, rq.dport != r.dport))
                     continue;
                  ans.verdict = r.accept ? VERDICT_ACCEPT : VERDICT_DROP;
                  ans.hit = 5'(i);
                  break;
               end
            end
            OP_INSERT, OP_APPEND: begin
               if (len >= RULES_PER_CHAIN) begin
                  ans.status = STATUS_NACK;
               end else begin
                  at = (rq.operation == OP_APPEND || int'(rq.position) > len) ?
                       len : int'(rq.position);
                  r.src = rq.src_ip;
                  r.src_mask = rq.src_netmask;
                  r.dst = rq.dst_ip;
                  r.dst_mask = rq.dst_netmask;
                  r.proto = rq.protocol;
                  r.sport = rq.sport;
                  r.dport = rq.dport;
                  r.flags = rq.rule_flags;
                  r.accept = rq.rule_accept;
                  for (i = len; i > at; i--)
                     rules[rq.chain][i] = rules[rq.chain][i - 1];
                  rules[rq.chain][at] = r;
                  counts[rq.chain] = len + 1;
               end
            end
            default: begin
               if (int'(rq.position) >= len) begin
                  ans.status = STATUS_NACK;
               end else begin
                  for (i = int'(rq.position); i + 1 < len; i++)
                     rules[rq.chain][i] = rules[rq.chain][i + 1];
                  counts[rq.chain] = len - 1;
               end
            end
         endcase
         pending_answers.insert(pending_answers.size(), ans);
      endfunction

      function void check_answer(logic status, logic [1:0] verdict, logic [4:0] hit);
         answer_type ans;
         if (pending_answers.size() == 0) begin
            $display("%0t: result with no transaction pending: status %b verdict %0d hit %0d",
                     $time, status, verdict, hit);
            failures++;
            return;
         end
         ans = pending_answers.pop_front();
         if (status !== ans.status) begin
            $display("%0t: status expected %b actual %b", $time, ans.status, status);
            failures++;
         end
         if (verdict !== ans.verdict) begin
            $display("%0t: verdict expected %0d actual %0d", $time, ans.verdict, verdict);
            failures++;
         end
         if (hit !== ans.hit) begin
            $display("%0t: hit_position expected %0d actual %0d", $time, ans.hit, hit);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_operation;
   logic        req_chain;
   logic [7:0]  req_position;
   logic [31:0] req_src_ip;
   logic [31:0] req_src_netmask;
   logic [31:0] req_dst_ip;
   logic [31:0] req_dst_netmask;
   logic [7:0]  req_protocol;
   logic [15:0] req_sport;
   logic [15:0] req_dport;
   logic [9:0]  req_rule_flags;
   logic        req_rule_accept;
   logic        rsp_valid;
   logic        rsp_status;
   logic [1:0]  rsp_verdict;
   logic [4:0]  rsp_hit_position;

   verdict_tracker_type tracker;
   request_type         current_req;

   first_match_packet_rule_table #(
      .RULES_PER_CHAIN(RULES_PER_CHAIN)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_chain(req_chain),
      .req_position(req_position),
      .req_src_ip(req_src_ip),
      .req_src_netmask(req_src_netmask),
      .req_dst_ip(req_dst_ip),
      .req_dst_netmask(req_dst_netmask),
      .req_protocol(req_protocol),
      .req_sport(req_sport),
      .req_dport(req_dport),
      .req_rule_flags(req_rule_flags),
      .req_rule_accept(req_rule_accept),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_verdict(rsp_verdict),
      .rsp_hit_position(rsp_hit_position)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            tracker.check_answer(rsp_status, rsp_verdict, rsp_hit_position);
         if (start && !busy)
            tracker.record_request(current_req);
      end
   end

   function automatic logic [31:0] random_mask();
      int plen;
      if ($urandom_range(0, 99) < 20)
         return $urandom;
      plen = $urandom_range(0, 32);
      return (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen));
   endfunction

   function automatic logic [7:0] random_proto();
      case ($urandom_range(0, 5))
         0, 1: return PROTO_TCP;
         2, 3: return PROTO_UDP;
         4: return 8'd1;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_port();
      case ($urandom_range(0, 9))
         0: return 16'd80;
         1: return 16'd443;
         2: return 16'd53;
         3: return 16'd0;
         4: return 16'hFFFF;
         5: return 16'd22;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic request_type rule_req(op_type op, logic ch, logic [7:0] pos,
                                            logic [31:0] src, logic [31:0] smask,
                                            logic [31:0] dst, logic [31:0] dmask,
                                            logic [7:0] proto, logic [15:0] sport,
                                            logic [15:0] dport, logic [9:0] flags,
                                            logic acc);
      request_type rq;
      rq.operation = op;
      rq.chain = ch;
      rq.position = pos;
      rq.src_ip = src;
      rq.src_netmask = smask;
      rq.dst_ip = dst;
      rq.dst_netmask = dmask;
      rq.protocol = proto;
      rq.sport = sport;
      rq.dport = dport;
      rq.rule_flags = flags;
      rq.rule_accept = acc;
      return rq;
   endfunction

   function automatic request_type packet_req(logic ch, logic [31:0] src, logic [31:0] dst,
                                              logic [7:0] proto, logic [15:0] sport,
                                              logic [15:0] dport);
      return rule_req(OP_CLASSIFY, ch, 8'($urandom), src, $urandom, dst, $urandom,
                      proto, sport, dport, 10'($urandom), 1'($urandom));
   endfunction

   function automatic request_type make_request(int mode);
      request_type rq;
      rule_type    r;
      int          len;
      int          pick;
      int          b;
      int          cls_lim;
      int          ins_lim;
      int          app_lim;
      rq.chain = 1'($urandom_range(0, 1));
      len = tracker.counts[rq.chain];
      rq.position = 8'($urandom);
      rq.src_ip = $urandom;
      rq.src_netmask = $urandom;
      rq.dst_ip = $urandom;
      rq.dst_netmask = $urandom;
      rq.protocol = random_proto();
      rq.sport = random_port();
      rq.dport = random_port();
      rq.rule_flags = 10'($urandom);
      rq.rule_accept = 1'($urandom);
      case (mode)
         0: begin cls_lim = 35; ins_lim = 65; app_lim = 95; end
         1: begin cls_lim = 35; ins_lim = 45; app_lim = 50; end
         default: begin cls_lim = 50; ins_lim = 65; app_lim = 80; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < cls_lim)
         rq.operation = OP_CLASSIFY;
      else if (pick < ins_lim)
         rq.operation = OP_INSERT;
      else if (pick < app_lim)
         rq.operation = OP_APPEND;
      else
         rq.operation = OP_DELETE;
      case (rq.operation)
         OP_CLASSIFY: begin
            if (len > 0 && $urandom_range(0, 99) < 65) begin
               r = tracker.rules[rq.chain][$urandom_range(0, len - 1)];
               rq.src_ip = r.src | ($urandom & ~r.src_mask);
               rq.dst_ip = r.dst | ($urandom & ~r.dst_mask);
               if (r.flags[CHK_PROTO])
                  rq.protocol = r.proto;
               else
                  rq.protocol = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
               if ($urandom_range(0, 99) < 10)
                  rq.protocol = 8'($urandom);
               rq.sport = r.sport;
               rq.dport = r.dport;
            end
         end
         OP_INSERT, OP_APPEND: begin
            rq.src_netmask = random_mask();
            rq.dst_netmask = random_mask();
            if ($urandom_range(0, 99) < 80) begin
               rq.src_ip = rq.src_ip & rq.src_netmask;
               rq.dst_ip = rq.dst_ip & rq.dst_netmask;
            end
            if ($urandom_range(0, 99) >= 10) begin
               rq.rule_flags[4:0] = 5'($urandom);
               for (b = 0; b < 5; b++)
                  rq.rule_flags[b + INV_OFS] = ($urandom_range(0, 99) < 15);
            end
            if (rq.operation == OP_INSERT) begin
               pick = $urandom_range(0, 99);
               if (pick < 70)
                  rq.position = 8'($urandom_range(0, len));
               else if (pick < 85)
                  rq.position = 8'(len + 1);
            end
         end
         default: begin
            if (len > 0 && $urandom_range(0, 99) < 80)
               rq.position = 8'($urandom_range(0, len - 1));
            else if ($urandom_range(0, 1))
               rq.position = 8'(len);
         end
      endcase
      return rq;
   endfunction

   task automatic send_item(request_type rq);
      @(negedge clock);
      current_req = rq;
      start = 1'b1;
      req_operation = rq.operation;
      req_chain = rq.chain;
      req_position = rq.position;
      req_src_ip = rq.src_ip;
      req_src_netmask = rq.src_netmask;
      req_dst_ip = rq.dst_ip;
      req_dst_netmask = rq.dst_netmask;
      req_protocol = rq.protocol;
      req_sport = rq.sport;
      req_dport = rq.dport;
      req_rule_flags = rq.rule_flags;
      req_rule_accept = rq.rule_accept;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_sender();
      @(negedge clock);
      start = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clock);
   endtask

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int idle_pct[3];
      int phase;
      int k;
      int mode;
      idle_pct[0] = 34;
      idle_pct[1] = 51;
      idle_pct[2] = 0;
      tracker = new();
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_CLASSIFY;
      req_chain = 1'b0;
      req_position = '0;
      req_src_ip = '0;
      req_src_netmask = '0;
      req_dst_ip = '0;
      req_dst_netmask = '0;
      req_protocol = '0;
      req_sport = '0;
      req_dport = '0;
      req_rule_flags = '0;
      req_rule_accept = 1'b0;
      current_req = rule_req(OP_CLASSIFY, 1'b0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                             8'd0, 16'd0, 16'd0, 10'd0, 1'b0);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty chain, bad delete, then rules built with insert, append and past-end insert.
      send_item(packet_req(1'b0, 32'h0A01_0203, 32'h0, PROTO_TCP, 16'd1, 16'd80));
      send_item(rule_req(OP_DELETE, 1'b0, 8'd0, $urandom, $urandom, $urandom, $urandom,
                         PROTO_TCP, 16'd0, 16'd0, 10'h000, 1'b1));
      send_item(rule_req(OP_APPEND, 1'b0, 8'd7, 32'h0A00_0000, 32'hFF00_0000, 32'h0,
                         32'h0, PROTO_TCP, 16'd0, 16'd0, 10'h005, 1'b1));
      send_item(rule_req(OP_INSERT, 1'b0, 8'd0, 32'h0, 32'h0, 32'h0, 32'h0,
                         PROTO_UDP, 16'd0, 16'd80, 10'h010, 1'b0));
      send_item(rule_req(OP_INSERT, 1'b0, 8'd200, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                         10'h3FF, 1'b1));
      send_item(rule_req(OP_APPEND, 1'b0, 8'd255, $urandom, $urandom, $urandom, $urandom,
                         8'd0, 16'd0, 16'd0, 10'h000, 1'b0));
      send_item(packet_req(1'b0, 32'h0A01_0203, 32'h0, PROTO_TCP, 16'd1, 16'd80));
      send_item(packet_req(1'b0, 32'h0A01_0203, 32'h0, PROTO_TCP, 16'd1, 16'd81));
      send_item(packet_req(1'b0, 32'h0A01_0203, 32'h0, 8'd1, 16'd1, 16'd80));
      send_item(packet_req(1'b0, 32'h0, 32'h0, PROTO_UDP, 16'd0, 16'd0));
      send_item(packet_req(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF));
      send_item(packet_req(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PROTO_TCP, 16'hFFFF,
                           16'hFFFF));
      send_item(rule_req(OP_DELETE, 1'b0, 8'd4, 32'h0, 32'h0, 32'h0, 32'h0,
                         8'd0, 16'd0, 16'd0, 10'h000, 1'b0));
      send_item(rule_req(OP_DELETE, 1'b0, 8'd255, 32'h0, 32'h0, 32'h0, 32'h0,
                         8'd0, 16'd0, 16'd0, 10'h000, 1'b0));
      send_item(rule_req(OP_DELETE, 1'b0, 8'd1, 32'h0, 32'h0, 32'h0, 32'h0,
                         8'd0, 16'd0, 16'd0, 10'h000, 1'b0));
      send_item(packet_req(1'b0, 32'h0A01_0203, 32'h0, PROTO_TCP, 16'd1, 16'd81));
      send_item(rule_req(OP_APPEND, 1'b1, 8'd0, $urandom, $urandom, $urandom, $urandom,
                         8'($urandom), 16'($urandom), 16'($urandom), 10'h000, 1'b1));
      send_item(packet_req(1'b1, $urandom, $urandom, 8'hFF, 16'($urandom),
                           16'($urandom)));
      send_item(packet_req(1'b1, $urandom, $urandom, PROTO_UDP, 16'($urandom),
                           16'($urandom)));
      send_item(rule_req(OP_INSERT, 1'b1, 8'd1, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0,
                         32'h0, PROTO_UDP, 16'd53, 16'd53, 10'h001, 1'b0));
      send_item(rule_req(OP_DELETE, 1'b1, 8'd0, 32'h0, 32'h0, 32'h0, 32'h0,
                         8'd0, 16'd0, 16'd0, 10'h000, 1'b0));
      send_item(packet_req(1'b1, 32'hC0A8_1234, 32'h0, PROTO_UDP, 16'd0, 16'd0));

      mode = 2;
      for (phase = 0; phase < 3; phase++) begin
         for (k = 0; k < 250; k++) begin
            if (k % 50 == 0)
               mode = $urandom_range(0, 2);
            if ($urandom_range(0, 99) < idle_pct[phase])
               idle_sender();
            send_item(make_request(mode));
         end
      end

      @(negedge clock);
      start = 1'b0;
      while (tracker.pending_answers.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending_answers.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== first_match_packet_rule_table.f =====
hdl/fmprt_pkg.sv
hdl/fmprt_rule_mem.sv
hdl/fmprt_match.sv
hdl/first_match_packet_rule_table.sv
test/first_match_packet_rule_table_test.sv
